// ===== src/vpfs_pkg.sv =====
// Package for the vblank phase locked frame scheduler.
// Holds beat structs, register indexes, op codes and sequencer states.
package vpfs_pkg;

    localparam logic [1:0] OP_VBLANK = 2'd0;
    localparam logic [1:0] OP_ANCHOR = 2'd1;
    localparam logic [1:0] OP_FRAME  = 2'd2;

    localparam logic [1:0] REG_TARGET_PERIOD   = 2'd0;
    localparam logic [1:0] REG_MARGIN          = 2'd1;
    localparam logic [1:0] REG_RESYNC_INTERVAL = 2'd2;

    localparam logic [31:0] TARGET_RESET = 32'd166667;
    localparam logic [31:0] MARGIN_RESET = 32'd20000;
    localparam logic [15:0] RESYNC_RESET = 16'd60;

    typedef struct packed {
        logic [1:0]  op;
        logic [62:0] now_ticks;
    } in_beat_t;

    typedef struct packed {
        logic [62:0]        wait_ticks;
        logic signed [63:0] next_present;
        logic [62:0]        period_estimate;
        logic               sample_accepted;
        logic               reanchored;
        logic               resynced;
        logic               phase_locked;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ANCHOR_DIV,
        ST_ANCHOR_FIN,
        ST_FRAME_ADV,
        ST_SNAP_START,
        ST_SNAP_DIV,
        ST_SNAP_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

// ===== src/vblank_phase_locked_frame_scheduler_top.sv =====
// Top level of the vblank phase locked frame scheduler.
// Depends on vpfs_pkg and vpfs_div.
//
// Usage: events arrive as beats on the s_ channel (op, now_ticks); each
// beat yields exactly one result beat on the m_ channel. Configuration is
// written through cfg_we/cfg_index/cfg_data while the block is idle.
// Path: a vblank beat runs decode then output; an anchor beat with a vblank
// seen, a nonzero period and now at or past the first slot adds the anchor
// divide and finish states; a frame beat adds frame advance, plus snap
// start, snap divide and snap finish when the periodic snap runs.
// One beat is worked on at a time; s_ready is low from acceptance until the
// result beat is taken, and the next beat can be accepted in the cycle after
// that. A stalled receiver holds the result in the output register and
// s_ready stays low. Reset restores the register defaults, the period
// estimate, and clears the schedule, last vblank and frame count.
// Only the low TIME_BITS of the schedule are kept and it is sign extended.
module vblank_phase_locked_frame_scheduler_top #(
    parameter int TIME_BITS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  vpfs_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output vpfs_pkg::out_beat_t  m_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    localparam logic [63:0] TMASK = (TIME_BITS == 64) ? {64{1'b1}}
                                    : ((64'd1 << TIME_BITS) - 64'd1);
    localparam logic [63:0] SBIT = 64'd1 << (TIME_BITS - 1);

    function automatic logic [63:0] tsext(input logic [63:0] u);
        tsext = ((u & TMASK) ^ SBIT) - SBIT;
    endfunction

    vpfs_pkg::state_t state_reg, state_next;
    logic [31:0] tp_reg, mg_reg;
    logic [15:0] ri_reg;
    logic [62:0] lv_reg, lv_next;
    logic [62:0] est_reg, est_next;
    logic [63:0] np_reg, np_next;
    logic [15:0] fs_reg, fs_next;
    logic [15:0] fs_inc;
    logic [1:0]  op_reg;
    logic [62:0] now_reg;
    logic [63:0] tmp_reg, tmp_next;
    logic        div_start;
    logic [63:0] div_a;
    logic [62:0] div_b;
    logic [63:0] div_rem;
    vpfs_pkg::div_ctl_t dctl;
    vpfs_pkg::out_beat_t res_reg, res_next;
    logic        mv_reg, mv_next;

    logic [63:0] tp64, mg64, lv64, est64, now64;
    logic [63:0] delta, dsum, dsx, ahead, nx0, sdelta, half, mag, ssum;
    logic signed [64:0] vdel, efix;
    logic signed [64:0] ediff;

    assign tp64   = {32'd0, tp_reg};
    assign mg64   = {32'd0, mg_reg};
    assign lv64   = {1'b0, lv_reg};
    assign est64  = {1'b0, est_reg};
    assign now64  = {1'b0, now_reg};
    assign fs_inc = fs_reg + 16'd1;

    vpfs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .ctl      (dctl),
        .remainder(div_rem)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vpfs_pkg::ST_IDLE:
                if (s_valid && s_ready) state_next = vpfs_pkg::ST_DECODE;
            vpfs_pkg::ST_DECODE: begin
                if (op_reg == vpfs_pkg::OP_ANCHOR && lv_reg != '0 && tp_reg != '0
                    && !dsx[63]) begin
                    state_next = vpfs_pkg::ST_ANCHOR_DIV;
                end else if (op_reg == vpfs_pkg::OP_FRAME) begin
                    state_next = vpfs_pkg::ST_FRAME_ADV;
                end else begin
                    state_next = vpfs_pkg::ST_OUT;
                end
            end
            vpfs_pkg::ST_ANCHOR_DIV:
                if (dctl.done) state_next = vpfs_pkg::ST_ANCHOR_FIN;
            vpfs_pkg::ST_ANCHOR_FIN: state_next = vpfs_pkg::ST_OUT;
            vpfs_pkg::ST_FRAME_ADV: begin
                if (fs_inc >= ri_reg && lv_reg != '0 && est_reg != '0)
                    state_next = vpfs_pkg::ST_SNAP_START;
                else
                    state_next = vpfs_pkg::ST_OUT;
            end
            vpfs_pkg::ST_SNAP_START: state_next = vpfs_pkg::ST_SNAP_DIV;
            vpfs_pkg::ST_SNAP_DIV:
                if (dctl.done) state_next = vpfs_pkg::ST_SNAP_FIN;
            vpfs_pkg::ST_SNAP_FIN: state_next = vpfs_pkg::ST_OUT;
            vpfs_pkg::ST_OUT:
                if (!mv_reg || m_ready) state_next = vpfs_pkg::ST_IDLE;
            default: state_next = vpfs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        lv_next   = lv_reg;
        est_next  = est_reg;
        np_next   = np_reg;
        fs_next   = fs_reg;
        tmp_next  = tmp_reg;
        res_next  = res_reg;
        mv_next   = mv_reg;
        div_start = 1'b0;
        div_a     = tmp_reg;
        div_b     = {31'd0, tp_reg};
        delta     = now64 - lv64;
        vdel      = {1'b0, delta};
        ediff     = vdel - {2'b0, est_reg};
        efix      = (ediff < 0) ? ediff + 65'sd15 : ediff;
        nx0       = lv64 + tp64 - mg64;
        dsum      = now64 - nx0;
        dsx       = tsext(dsum);
        ahead     = tsext(np_reg - now64);
        sdelta    = tsext(np_reg + mg64 - lv64);
        half      = est64 >> 1;
        mag       = ~sdelta + 64'd1;
        if (!sdelta[63]) ssum = sdelta + half;
        else ssum = (half > mag) ? half - mag : 64'd0;
        if (m_valid && m_ready) mv_next = 1'b0;
        case (state_reg)
            vpfs_pkg::ST_IDLE: begin
                if (s_valid && s_ready) res_next = '0;
            end
            vpfs_pkg::ST_DECODE: begin
                case (op_reg)
                    vpfs_pkg::OP_VBLANK: begin
                        lv_next = now_reg;
                        if (lv_reg != '0 && delta > (tp64 >> 1)
                            && delta < (tp64 << 1)) begin
                            est_next = 63'(est64 + {{4{efix[64]}}, efix[63:4]});
                            res_next.sample_accepted = 1'b1;
                        end
                    end
                    vpfs_pkg::OP_ANCHOR: begin
                        fs_next = '0;
                        if (lv_reg != '0) begin
                            res_next.phase_locked = 1'b1;
                            np_next = nx0 & TMASK;
                            div_start = (tp_reg != '0) && !dsx[63];
                            div_a = dsx;
                        end else begin
                            np_next = (now64 + tp64) & TMASK;
                        end
                    end
                    vpfs_pkg::OP_FRAME: begin
                        if (!ahead[63] && ahead != '0) begin
                            res_next.wait_ticks = ahead[62:0];
                        end else if (ahead[63] && ($signed(ahead) < -$signed(tp64))) begin
                            np_next = ((lv_reg != '0) ? nx0 : now64 + tp64) & TMASK;
                            fs_next = '0;
                            res_next.reanchored = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            vpfs_pkg::ST_ANCHOR_DIV: ;
            vpfs_pkg::ST_ANCHOR_FIN: begin
                np_next = (now64 - div_rem + tp64) & TMASK;
            end
            vpfs_pkg::ST_FRAME_ADV: begin
                np_next = (np_reg + tp64) & TMASK;
                fs_next = (fs_inc >= ri_reg) ? 16'd0 : fs_inc;
            end
            vpfs_pkg::ST_SNAP_START: begin
                div_start = 1'b1;
                div_b     = est_reg;
                div_a     = ssum;
                tmp_next  = ssum;
            end
            vpfs_pkg::ST_SNAP_DIV: ;
            vpfs_pkg::ST_SNAP_FIN: begin
                np_next = (lv64 + tmp_reg - div_rem - mg64) & TMASK;
                res_next.resynced = 1'b1;
            end
            vpfs_pkg::ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    res_next.next_present = tsext(np_reg);
                    res_next.period_estimate = est_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vpfs_pkg::ST_IDLE;
            tp_reg    <= vpfs_pkg::TARGET_RESET;
            mg_reg    <= vpfs_pkg::MARGIN_RESET;
            ri_reg    <= vpfs_pkg::RESYNC_RESET;
            lv_reg    <= '0;
            est_reg   <= 63'(vpfs_pkg::TARGET_RESET);
            np_reg    <= '0;
            fs_reg    <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            lv_reg    <= lv_next;
            est_reg   <= est_next;
            np_reg    <= np_next;
            fs_reg    <= fs_next;
            mv_reg    <= mv_next;
            if (cfg_we) begin
                case (cfg_index)
                    vpfs_pkg::REG_TARGET_PERIOD: begin
                        tp_reg  <= cfg_data;
                        est_reg <= {31'd0, cfg_data};
                    end
                    vpfs_pkg::REG_MARGIN: mg_reg <= cfg_data;
                    vpfs_pkg::REG_RESYNC_INTERVAL: ri_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
        tmp_reg <= tmp_next;
        res_reg <= res_next;
        if (s_valid && s_ready) begin
            op_reg  <= s_data.op;
            now_reg <= s_data.now_ticks;
        end
    end

    assign s_ready = (state_reg == vpfs_pkg::ST_IDLE) && !mv_reg;
    assign m_valid = mv_reg;
    assign m_data  = res_reg;

    a_single_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones({m_data.sample_accepted, m_data.reanchored,
                                m_data.phase_locked}) <= 1)
        else $error("more than one event flag set");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        dctl.busy |-> !s_ready)
        else $error("ready while divider busy");
endmodule

// ===== src/vpfs_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on vpfs_pkg for the control struct.
module vpfs_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [63:0]       dividend,
    input  logic [62:0]       divisor,
    output vpfs_pkg::div_ctl_t ctl,
    output logic [63:0]       remainder
);
    logic [63:0] q_reg, q_next;
    logic [63:0] r_reg, r_next;
    logic [62:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[63]} - {2'b0, d_reg};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[64]) begin
                r_next = trial[63:0];
                q_next = {q_reg[62:0], 1'b1};
            end else begin
                r_next = {r_reg[62:0], q_reg[63]};
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign remainder = r_reg;
endmodule
